// ===== hdl/xtea_block_cipher_assert.svh =====
// assertion macros for the xtea block cipher
`ifndef XTEA_BLOCK_CIPHER_ASSERT_SVH
`define XTEA_BLOCK_CIPHER_ASSERT_SVH
`ifndef SYNTH
`define XTEA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define XTEA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define XTEA_ASSERT(lbl, prop, msg)
`define XTEA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hdl/xtea_pkg.sv =====
// shared types, constants and functions for the xtea block cipher
package xtea_pkg;

  localparam int unsigned HALF_ROUNDS_DEF = 64;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned BLK_W = 64;
  localparam int unsigned KEY_IDX_W = 2;
  localparam logic [WORD_W-1:0] DELTA = 32'h9E37_79B9;

  localparam logic [KEY_IDX_W-1:0] KEY_IDX_0 = 2'd0;
  localparam logic [KEY_IDX_W-1:0] KEY_IDX_1 = 2'd1;
  localparam logic [KEY_IDX_W-1:0] KEY_IDX_2 = 2'd2;
  localparam logic [KEY_IDX_W-1:0] KEY_IDX_3 = 2'd3;

  typedef logic [3:0][WORD_W-1:0] key_set_t;

  typedef struct packed {
    logic             vld;
    logic             func;
    logic [BLK_W-1:0] data;
  } pipe_word_t;

  // running sum after r additions of delta, elaboration only
  function automatic logic [WORD_W-1:0] round_sum(input int unsigned r);
    logic [63:0] p;
    p = 64'(r) * 64'(DELTA);
    return p[WORD_W-1:0];
  endfunction

  function automatic logic [WORD_W-1:0] mix(input logic [WORD_W-1:0] v);
    return ((v << 4) ^ (v >> 5)) + v;
  endfunction

endpackage

// ===== hdl/xtea_key_bank.sv =====
// key word registers written through the configuration port
module xtea_key_bank import xtea_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [KEY_IDX_W-1:0] cfg_idx,
  input  logic [WORD_W-1:0]    cfg_wdata,
  output key_set_t             keys
);

  key_set_t keys_r;
  key_set_t keys_nxt;

  always_comb begin
    keys_nxt = keys_r;
    if (cfg_we) begin
      case (cfg_idx)
        KEY_IDX_0: keys_nxt[0] = cfg_wdata;
        KEY_IDX_1: keys_nxt[1] = cfg_wdata;
        KEY_IDX_2: keys_nxt[2] = cfg_wdata;
        KEY_IDX_3: keys_nxt[3] = cfg_wdata;
        default:   keys_nxt = keys_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keys_r <= '0;
    end else begin
      keys_r <= keys_nxt;
    end
  end

  assign keys = keys_r;

endmodule

// ===== hdl/xtea_stage.sv =====
// one half round of xtea, both directions, with its pipeline register
module xtea_stage import xtea_pkg::*; #(
  parameter int unsigned STAGE_IDX = 0,
  parameter int unsigned NPAIR     = HALF_ROUNDS_DEF / 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  key_set_t   keys,
  input  pipe_word_t in_w,
  output pipe_word_t out_w
);

  localparam logic IS_ODD = 1'(STAGE_IDX % 2);
  localparam int unsigned ENC_R = STAGE_IDX / 2;
  localparam int unsigned DEC_R = NPAIR - 1 - STAGE_IDX / 2;
  // encrypt selects the key by sum[1:0] then sum[12:11], decrypt by sum[12:11] then sum[1:0]
  localparam logic [WORD_W-1:0] ENC_SUM = IS_ODD ? round_sum(ENC_R + 1) : round_sum(ENC_R);
  localparam logic [WORD_W-1:0] DEC_SUM = IS_ODD ? round_sum(DEC_R) : round_sum(DEC_R + 1);
  localparam logic [1:0] ENC_SEL = IS_ODD ? ENC_SUM[12:11] : ENC_SUM[1:0];
  localparam logic [1:0] DEC_SEL = IS_ODD ? DEC_SUM[1:0] : DEC_SUM[12:11];

  logic              src_lo;
  logic [WORD_W-1:0] v_hi;
  logic [WORD_W-1:0] v_lo;
  logic [WORD_W-1:0] src;
  logic [WORD_W-1:0] dst;
  logic [WORD_W-1:0] rk;
  logic [WORD_W-1:0] t;
  logic [WORD_W-1:0] res;
  logic [BLK_W-1:0]  data_nxt;

  logic              vld_r;
  logic              func_r;
  logic [BLK_W-1:0]  data_r;

  always_comb begin
    v_hi   = in_w.data[BLK_W-1:WORD_W];
    v_lo   = in_w.data[WORD_W-1:0];
    // low half feeds the mix when the high half is the one updated
    src_lo = (in_w.func == IS_ODD);
    src    = src_lo ? v_lo : v_hi;
    dst    = src_lo ? v_hi : v_lo;
    rk     = in_w.func ? (DEC_SUM + keys[DEC_SEL]) : (ENC_SUM + keys[ENC_SEL]);
    t      = mix(src) ^ rk;
    res    = in_w.func ? (dst - t) : (dst + t);
    data_nxt = src_lo ? {res, v_lo} : {v_hi, res};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_w.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      func_r <= in_w.func;
      data_r <= data_nxt;
    end
  end

  assign out_w = '{vld: vld_r, func: func_r, data: data_r};

endmodule

// ===== hdl/xtea_block_cipher.sv =====
// xtea block cipher top level: key bank and a pipeline of one half round per stage
// throughput: one word per cycle while no result is held, one register stage per half round
// a held result freezes the whole pipeline and stalls the input for that cycle
// reset (rst_n low, synchronous) clears all valid bits and the key words to zero
module xtea_block_cipher import xtea_pkg::*; #(
  parameter int unsigned HALF_ROUNDS = HALF_ROUNDS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [KEY_IDX_W-1:0] cfg_idx,
  input  logic [WORD_W-1:0]    cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_func,
  input  logic [BLK_W-1:0]     in_data_in,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [BLK_W-1:0]     out_data_out
);

`include "xtea_block_cipher_assert.svh"

  localparam int unsigned NPAIR  = HALF_ROUNDS / 2;
  localparam int unsigned NSTAGE = 2 * NPAIR;

  key_set_t          keys;
  pipe_word_t        stage_w [NSTAGE+1];
  logic [NSTAGE-1:0] vld_vec;
  logic              en;
  logic              key0_we;

  xtea_key_bank u_keys (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .keys      (keys)
  );

  // the last stage register is the output register
  assign en         = !(out_valid && out_stall);
  assign in_stall   = !en;
  assign stage_w[0] = '{vld: in_valid, func: in_func, data: in_data_in};

  for (genvar g = 0; g < NSTAGE; g++) begin : g_stage
    xtea_stage #(
      .STAGE_IDX (g),
      .NPAIR     (NPAIR)
    ) u_stage (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .keys  (keys),
      .in_w  (stage_w[g]),
      .out_w (stage_w[g+1])
    );
    assign vld_vec[g] = stage_w[g+1].vld;
  end

  assign out_valid    = stage_w[NSTAGE].vld;
  assign out_data_out = stage_w[NSTAGE].data;

  assign key0_we = cfg_we && (cfg_idx == KEY_IDX_0);

  `XTEA_ASSERT_NEXT(a_freeze_holds_valids, !en, $stable(vld_vec), "valid bits moved while stalled")
  `XTEA_ASSERT_NEXT(a_last_stage_reaches_out, en && vld_vec[NSTAGE-2], out_valid, "word dropped")
  `XTEA_ASSERT_NEXT(a_key0_write, key0_we, keys[0] == $past(cfg_wdata), "key word 0 not written")

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for the xtea block cipher: driver, monitor and block predictor
module testbench;
  import xtea_pkg::*;

  localparam int unsigned HALF_RNDS = HALF_ROUNDS_DEF;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  typedef struct {
    logic             func;
    logic [BLK_W-1:0] blk;
  } block_req_t;

  typedef struct {
    block_req_t       req;
    logic [BLK_W-1:0] result;
  } block_want_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [KEY_IDX_W-1:0] cfg_idx = KEY_IDX_0;
  logic [WORD_W-1:0]    cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_func = OP_ENCRYPT;
  logic [BLK_W-1:0]     in_data_in = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [BLK_W-1:0]     out_data_out;

  block_req_t  block_reqs[$];
  block_want_t want_blocks[$];
  key_set_t    key_now = '0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;

  xtea_block_cipher #(.HALF_ROUNDS(HALF_RNDS)) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_func      (in_func),
    .in_data_in   (in_data_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data_out (out_data_out)
  );

  always #5 clk = ~clk;

  function automatic logic [WORD_W-1:0] feistel_mix(input logic [WORD_W-1:0] v);
    return ((v << 4) ^ (v >> 5)) + v;
  endfunction

  // full xtea over one block with the given key words
  function automatic logic [BLK_W-1:0] xtea_crypt(input logic op, input logic [BLK_W-1:0] blk,
                                                  input key_set_t k);
    logic [WORD_W-1:0] v0;
    logic [WORD_W-1:0] v1;
    logic [WORD_W-1:0] s_lo;
    logic [WORD_W-1:0] s_hi;
    int unsigned       pairs;
    v0 = blk[BLK_W-1:WORD_W];
    v1 = blk[WORD_W-1:0];
    pairs = HALF_RNDS / 2;
    if (op == OP_ENCRYPT) begin
      for (int unsigned r = 0; r < pairs; r++) begin
        s_lo = WORD_W'(r) * DELTA;
        s_hi = WORD_W'(r + 1) * DELTA;
        v0 += feistel_mix(v1) ^ (s_lo + k[s_lo[1:0]]);
        v1 += feistel_mix(v0) ^ (s_hi + k[s_hi[12:11]]);
      end
    end else begin
      for (int unsigned r = pairs; r > 0; r--) begin
        s_lo = WORD_W'(r - 1) * DELTA;
        s_hi = WORD_W'(r) * DELTA;
        v1 -= feistel_mix(v0) ^ (s_hi + k[s_hi[12:11]]);
        v0 -= feistel_mix(v1) ^ (s_lo + k[s_lo[1:0]]);
      end
    end
    return {v0, v1};
  endfunction

  // driver: holds a stalled word, otherwise offers the next pending block
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        want_blocks.push_back('{req: block_reqs[0],
                                result: xtea_crypt(block_reqs[0].func, block_reqs[0].blk,
                                                   key_now)});
        void'(block_reqs.pop_front());
      end
      if (block_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid   <= 1'b1;
        in_func    <= block_reqs[0].func;
        in_data_in <= block_reqs[0].blk;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: random back-pressure and in-order compare
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (want_blocks.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected word: data_out %h", out_data_out);
        end else begin
          if (out_data_out !== want_blocks[0].result) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("data_out mismatch: func %0d in %h expected %h got %h",
                       want_blocks[0].req.func, want_blocks[0].req.blk,
                       want_blocks[0].result, out_data_out);
          end
          void'(want_blocks.pop_front());
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  task automatic write_key(input logic [KEY_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    key_now[idx] = val;
  endtask

  task automatic load_keys(input logic [WORD_W-1:0] k0, input logic [WORD_W-1:0] k1,
                           input logic [WORD_W-1:0] k2, input logic [WORD_W-1:0] k3);
    write_key(KEY_IDX_0, k0);
    write_key(KEY_IDX_1, k1);
    write_key(KEY_IDX_2, k2);
    write_key(KEY_IDX_3, k3);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic add_block(input logic op, input logic [BLK_W-1:0] blk);
    block_reqs.push_back('{func: op, blk: blk});
  endtask

  // mostly random blocks, some decrypts of matching ciphertext, some with one half all zeros or all ones
  task automatic add_random_blocks(input int unsigned n);
    logic [BLK_W-1:0] blk;
    for (int unsigned i = 0; i < n; i++) begin
      blk = {$urandom, $urandom};
      case ($urandom_range(7))
        0: add_block(OP_DECRYPT, xtea_crypt(OP_ENCRYPT, blk, key_now));
        1: add_block(OP_ENCRYPT, xtea_crypt(OP_DECRYPT, blk, key_now));
        2: add_block(logic'($urandom_range(1)),
                     $urandom_range(1) ? {blk[BLK_W-1:WORD_W], {WORD_W{1'b0}}}
                                       : {{WORD_W{1'b1}}, blk[WORD_W-1:0]});
        default: add_block(logic'($urandom_range(1)), blk);
      endcase
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (block_reqs.size() != 0 || in_valid || want_blocks.size() != 0);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset key, directed corners
    send_idle_pct = 10;
    recv_idle_pct = 50;
    add_block(OP_ENCRYPT, 64'h0000_0000_0000_0000);
    add_block(OP_DECRYPT, 64'h0000_0000_0000_0000);
    add_block(OP_ENCRYPT, 64'hFFFF_FFFF_FFFF_FFFF);
    add_block(OP_DECRYPT, 64'hFFFF_FFFF_FFFF_FFFF);
    add_block(OP_ENCRYPT, 64'h8000_0000_0000_0001);
    add_block(OP_DECRYPT, 64'h0000_0001_8000_0000);
    add_block(OP_ENCRYPT, 64'hFFFF_FFFF_0000_0000);
    add_block(OP_DECRYPT, 64'h0000_0000_FFFF_FFFF);
    add_block(OP_ENCRYPT, 64'h0123_4567_89AB_CDEF);
    add_block(OP_DECRYPT, xtea_crypt(OP_ENCRYPT, 64'h0123_4567_89AB_CDEF, key_now));
    add_block(OP_ENCRYPT, 64'h5555_5555_AAAA_AAAA);
    add_block(OP_DECRYPT, 64'hAAAA_AAAA_5555_5555);
    wait_drained();

    // all-ones key
    load_keys(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_block(OP_ENCRYPT, 64'h0000_0000_0000_0000);
    add_block(OP_DECRYPT, 64'h0000_0000_0000_0000);
    add_block(OP_ENCRYPT, 64'hFFFF_FFFF_FFFF_FFFF);
    add_block(OP_DECRYPT, 64'hFFFF_FFFF_FFFF_FFFF);
    add_random_blocks(100);
    wait_drained();

    send_idle_pct = 50;
    recv_idle_pct = 10;
    load_keys($urandom, $urandom, $urandom, $urandom);
    add_random_blocks(200);
    wait_drained();

    // mixed extremes so each key word is distinguishable
    load_keys(32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001);
    add_random_blocks(150);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    load_keys($urandom, $urandom, $urandom, $urandom);
    add_random_blocks(230);
    wait_drained();

    repeat (HALF_RNDS + 16) @(posedge clk);
    if (mismatch_cnt == 0 && want_blocks.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
